// ===== rtl/lsp_pkg.sv =====
// Shared types, codes and scan tables for the line sensor position estimator.
`default_nettype none
package lsp_pkg;

  localparam int unsigned POS_W    = 7;
  localparam int unsigned ANG_W    = 15;
  localparam int unsigned SPACE_W  = 10;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned LAYOUT_W = 2;
  localparam int unsigned MAX_SENSORS = 16;
  localparam int unsigned SLOT_W   = 4;
  localparam int unsigned DVD_W    = 64;
  localparam int unsigned DVS_W    = 21;
  localparam logic [POS_W-1:0] CENTER_POS = 7'd45;

  localparam logic [CFG_IDX_W-1:0] CFG_LAYOUT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPACING = 1'b1;

  localparam logic [LAYOUT_W-1:0] LAYOUT_RIGHT  = 2'd0;
  localparam logic [LAYOUT_W-1:0] LAYOUT_LEFT   = 2'd1;
  localparam logic [LAYOUT_W-1:0] LAYOUT_MIDDLE = 2'd2;

  typedef struct packed {
    logic             back_lost;
    logic             front_lost;
    logic [POS_W-1:0] lateral;
    logic [POS_W-1:0] back_pos;
    logic [POS_W-1:0] front_pos;
  } lsp_item_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } lsp_div_req_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PREP, ST_SETUP, ST_ACC, ST_DIV1, ST_MUL2, ST_DIV2,
    ST_FIN, ST_DIV3, ST_OUT
  } lsp_state_t;

  // Physical sensor bit scanned in a slot; slots past the eighth map to themselves.
  function automatic logic [SLOT_W-1:0] scan_bit(logic [LAYOUT_W-1:0] mode,
                                                 logic [SLOT_W-1:0] slot);
    logic [SLOT_W-1:0] res;
    res = slot;
    if (slot < 4'd8) begin
      unique case (mode)
        LAYOUT_LEFT: res = slot;
        LAYOUT_MIDDLE: begin
          unique case (slot[2:0])
            3'd0: res = 4'd4;
            3'd1: res = 4'd3;
            3'd2: res = 4'd5;
            3'd3: res = 4'd2;
            3'd4: res = 4'd6;
            3'd5: res = 4'd1;
            3'd6: res = 4'd7;
            default: res = 4'd0;
          endcase
        end
        default: res = 4'd7 - slot;
      endcase
    end
    return res;
  endfunction

  function automatic logic [POS_W-1:0] scan_pos(logic [LAYOUT_W-1:0] mode,
                                                logic [SLOT_W-1:0] slot);
    logic [POS_W-1:0] res;
    res = '0;
    if (slot < 4'd8) begin
      unique case (mode)
        LAYOUT_LEFT: res = 7'(({3'b0, slot} + 7'd1) * 7'd10);
        LAYOUT_MIDDLE: begin
          unique case (slot[2:0])
            3'd0: res = 7'd50;
            3'd1: res = 7'd40;
            3'd2: res = 7'd60;
            3'd3: res = 7'd30;
            3'd4: res = 7'd70;
            3'd5: res = 7'd20;
            3'd6: res = 7'd80;
            default: res = 7'd10;
          endcase
        end
        default: res = 7'(7'd80 - {3'b0, slot} * 7'd10);
      endcase
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/lsp_front.sv =====
// Front end: take sensor samples, find bar positions, hold lost bars, form the items for the queue.
`default_nettype none
module lsp_front #(
  parameter int SENSORS_PER_BAR = 8
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire  [lsp_pkg::LAYOUT_W-1:0]   layout_mode,
  input  wire                            take,
  input  wire  [SENSORS_PER_BAR-1:0]     front_mask,
  input  wire  [SENSORS_PER_BAR-1:0]     back_mask,
  output lsp_pkg::lsp_item_t             item
);
  import lsp_pkg::*;

  logic [POS_W-1:0] held_front_r, held_front_nxt;
  logic [POS_W-1:0] held_back_r, held_back_nxt;
  logic [POS_W-1:0] fpos, bpos;
  logic             flost, blost;
  logic [POS_W:0]   psum;

  function automatic logic [POS_W:0] locate(logic [LAYOUT_W-1:0] mode,
                                            logic [SENSORS_PER_BAR-1:0] mask);
    logic [MAX_SENSORS-1:0] m16;
    logic                   found;
    logic [POS_W-1:0]       pos;
    logic [POS_W:0]         pair;
    m16   = MAX_SENSORS'(mask);
    found = 1'b0;
    pos   = '0;
    for (int i = 0; i < SENSORS_PER_BAR; i++) begin
      if (!found && m16[scan_bit(mode, SLOT_W'(i))]) begin
        found = 1'b1;
        pos   = scan_pos(mode, SLOT_W'(i));
        if (i + 1 < SENSORS_PER_BAR) begin
          if (m16[scan_bit(mode, SLOT_W'(i + 1))]) begin
            pair = {1'b0, pos} + {1'b0, scan_pos(mode, SLOT_W'(i + 1))};
            pos  = pair[POS_W:1];
          end
        end
      end
    end
    return {!found, pos};
  endfunction

  always_comb begin
    {flost, fpos} = locate(layout_mode, front_mask);
    {blost, bpos} = locate(layout_mode, back_mask);
    if (flost) fpos = held_front_r;
    if (blost) bpos = held_back_r;
    psum = {1'b0, fpos} + {1'b0, bpos};
    item.front_pos  = fpos;
    item.back_pos   = bpos;
    item.lateral    = psum[POS_W:1] - CENTER_POS;
    item.front_lost = flost;
    item.back_lost  = blost;
    held_front_nxt  = take ? fpos : held_front_r;
    held_back_nxt   = take ? bpos : held_back_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_front_r <= '0;
      held_back_r  <= '0;
    end else begin
      held_front_r <= held_front_nxt;
      held_back_r  <= held_back_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/lsp_fifo.sv =====
// Two-entry queue between the front end and the angle engine.
`default_nettype none
module lsp_fifo (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 push,
  input  lsp_pkg::lsp_item_t  push_data,
  output logic                full,
  input  wire                 pop,
  output logic                empty,
  output lsp_pkg::lsp_item_t  pop_data
);
  import lsp_pkg::*;

  lsp_item_t  mem_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full     = cnt_r == 2'd2;
  assign empty    = cnt_r == 2'd0;
  assign pop_data = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/lsp_div.sv =====
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module lsp_div (
  input  wire                          clk,
  input  wire                          rst_n,
  input  lsp_pkg::lsp_div_req_t        req,
  output logic                         done,
  output logic [lsp_pkg::DVD_W-1:0]    quotient
);
  import lsp_pkg::*;

  logic [DVD_W-1:0] dvd_r, dvd_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [5:0]       cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DVS_W:0]   rem_sh;

  assign done     = done_r;
  assign quotient = dvd_r;

  always_comb begin
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    rem_sh   = {rem_r, dvd_r[DVD_W-1]};
    if (req.start) begin
      dvd_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, dvs_r}) begin
        rem_nxt = DVS_W'(rem_sh - {1'b0, dvs_r});
        dvd_nxt = {dvd_r[DVD_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[DVS_W-1:0];
        dvd_nxt = {dvd_r[DVD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'(DVD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/lsp_back.sv =====
// Back end: series arctangent of the bar difference and the result register.
`default_nettype none
module lsp_back (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire  [lsp_pkg::SPACE_W-1:0]    bar_spacing,
  input  wire                            q_empty,
  input  lsp_pkg::lsp_item_t             q_data,
  output logic                           q_pop,
  output lsp_pkg::lsp_div_req_t          div_req,
  input  wire                            div_done,
  input  wire  [lsp_pkg::DVD_W-1:0]      div_quot,
  output logic                           out_valid,
  input  wire                            out_ready,
  output lsp_pkg::lsp_item_t             out_item,
  output logic [lsp_pkg::ANG_W-1:0]      out_angle
);
  import lsp_pkg::*;

  localparam int unsigned A_W   = 41;
  localparam int unsigned SUM_W = 42;
  localparam logic [5:0]  TERMS = 6'd48;

  lsp_state_t       st_r, st_nxt;
  lsp_item_t        item_r, item_nxt, oitem_r, oitem_nxt;
  logic [ANG_W-1:0] ang_r, ang_nxt, oang_r, oang_nxt;
  logic             ovalid_r, ovalid_nxt;
  logic             sign_r, sign_nxt, far_r, far_nxt, cph_r, cph_nxt;
  logic [SPACE_W-1:0] p_r, p_nxt, q_r, q_nxt;
  logic [19:0]      pp_r, pp_nxt, pq_r, pq_nxt;
  logic [20:0]      den_r, den_nxt;
  logic [A_W-1:0]   a_r, a_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt, c_r, c_nxt;
  logic [5:0]       n_r, n_nxt;
  logic [POS_W-1:0] mag;
  logic [SUM_W-1:0] v;
  logic [SUM_W:0]   vr;
  logic [ANG_W-1:0] r;

  assign out_valid = ovalid_r;
  assign out_item  = oitem_r;
  assign out_angle = oang_r;

  always_comb begin
    st_nxt = st_r; item_nxt = item_r; ang_nxt = ang_r;
    oitem_nxt = oitem_r; oang_nxt = oang_r;
    ovalid_nxt = ovalid_r & ~out_ready;
    sign_nxt = sign_r; far_nxt = far_r; cph_nxt = cph_r;
    p_nxt = p_r; q_nxt = q_r; pp_nxt = pp_r; pq_nxt = pq_r; den_nxt = den_r;
    a_nxt = a_r; sum_nxt = sum_r; c_nxt = c_r; n_nxt = n_r;
    q_pop = 1'b0;
    div_req = '{start: 1'b0, dividend: '0, divisor: den_r};
    mag = (item_r.front_pos >= item_r.back_pos) ? item_r.front_pos - item_r.back_pos
                                                : item_r.back_pos - item_r.front_pos;
    v  = far_r ? SUM_W'({c_r, 1'b0} - {1'b0, div_quot[SUM_W-1:0]}) : div_quot[SUM_W-1:0];
    vr = {1'b0, v} + ((SUM_W+1)'(1) << 26);
    r  = vr[SUM_W-1:27];
    unique case (st_r)
      ST_IDLE: begin
        if (!q_empty && !ovalid_r) begin
          q_pop = 1'b1;
          item_nxt = q_data;
          st_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        sign_nxt = item_r.front_pos < item_r.back_pos;
        if (mag == '0) begin
          ang_nxt = '0;
          st_nxt = ST_OUT;
        end else if ({3'b0, mag} > bar_spacing) begin
          far_nxt = 1'b1; cph_nxt = 1'b1;
          p_nxt = SPACE_W'(1); q_nxt = SPACE_W'(1);
          st_nxt = ST_SETUP;
        end else begin
          far_nxt = 1'b0; cph_nxt = 1'b0;
          p_nxt = {3'b0, mag}; q_nxt = bar_spacing;
          st_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        pp_nxt  = {10'b0, p_r} * {10'b0, p_r};
        pq_nxt  = {10'b0, p_r} * {10'b0, q_r};
        den_nxt = {1'b0, {10'b0, p_r} * {10'b0, p_r}} + {1'b0, {10'b0, q_r} * {10'b0, q_r}};
        a_nxt   = A_W'(1) << 40;
        sum_nxt = '0;
        n_nxt   = 6'd1;
        st_nxt  = ST_ACC;
      end
      ST_ACC: begin
        sum_nxt = sum_r + {1'b0, a_r};
        div_req.start = 1'b1;
        div_req.dividend = DVD_W'(a_r) * DVD_W'(pp_r);
        st_nxt = ST_DIV1;
      end
      ST_DIV1: begin
        if (div_done) begin
          a_nxt = div_quot[A_W-1:0];
          st_nxt = ST_MUL2;
        end
      end
      ST_MUL2: begin
        div_req.start = 1'b1;
        div_req.dividend = DVD_W'(a_r) * DVD_W'({n_r, 1'b0});
        div_req.divisor = DVS_W'({n_r, 1'b1});
        st_nxt = ST_DIV2;
      end
      ST_DIV2: begin
        if (div_done) begin
          a_nxt = div_quot[A_W-1:0];
          n_nxt = n_r + 6'd1;
          st_nxt = (n_r == TERMS) ? ST_FIN : ST_ACC;
        end
      end
      ST_FIN: begin
        div_req.start = 1'b1;
        div_req.dividend = DVD_W'(sum_r) * DVD_W'(pq_r);
        st_nxt = ST_DIV3;
      end
      ST_DIV3: begin
        if (div_done) begin
          if (cph_r) begin
            // pi/4 done; now the complementary ratio spacing/difference
            c_nxt = div_quot[SUM_W-1:0];
            cph_nxt = 1'b0;
            p_nxt = bar_spacing;
            q_nxt = {3'b0, mag};
            st_nxt = ST_SETUP;
          end else begin
            ang_nxt = sign_r ? ANG_W'(-r) : r;
            st_nxt = ST_OUT;
          end
        end
      end
      ST_OUT: begin
        oitem_nxt = item_r;
        oang_nxt = ang_r;
        ovalid_nxt = 1'b1;
        st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt; ang_r <= ang_nxt; oitem_r <= oitem_nxt; oang_r <= oang_nxt;
    sign_r <= sign_nxt; far_r <= far_nxt; cph_r <= cph_nxt;
    p_r <= p_nxt; q_r <= q_nxt; pp_r <= pp_nxt; pq_r <= pq_nxt; den_r <= den_nxt;
    a_r <= a_nxt; sum_r <= sum_nxt; c_r <= c_nxt; n_r <= n_nxt;
    if (!rst_n) begin
      st_r     <= ST_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/line_sensor_position_estimator.sv =====
// Top level of the line sensor position estimator.
// The serial divider sets the processing time: it is used twice per series term over 48
//   terms, the series runs twice when the bar difference exceeds the spacing, and not
//   at all when the bars agree. The back end takes one item at a time; a two-entry
//   queue keeps taking input while it has room.
// Reset (rst_n, synchronous, active low): layout right, spacing 100, held positions 0.
`default_nettype none
module line_sensor_position_estimator #(
  parameter int SENSORS_PER_BAR = 8
) (
  input  wire                   clk,
  input  wire                   rst_n,
  // configuration: index 0 layout_mode, index 1 bar_spacing
  input  wire                   cfg_we,
  input  wire  [0:0]            cfg_index,
  input  wire  [9:0]            cfg_data,
  input  wire                   in_tvalid,
  output logic                  in_tready,
  // front_mask, back_mask (from bit 0 up), zero padded to bytes
  input  wire  [((2*SENSORS_PER_BAR+7)/8)*8-1:0] in_tdata,
  output logic                  out_tvalid,
  input  wire                   out_tready,
  // front_position, back_position, lateral_offset, heading_angle, front_lost,
  // back_lost (from bit 0 up), zero padded
  output logic [39:0]           out_tdata
);
  import lsp_pkg::*;

  logic [LAYOUT_W-1:0] layout_r, layout_nxt;
  logic [SPACE_W-1:0]  spacing_r, spacing_nxt;
  logic                take, q_full, q_empty, q_pop, div_done;
  lsp_item_t           f_item, q_item, o_item;
  lsp_div_req_t        div_req;
  logic [DVD_W-1:0]    div_quot;
  logic [ANG_W-1:0]    o_angle;

  // register writes; mode 3 behaves as right, handled by the scan tables
  always_comb begin
    layout_nxt  = layout_r;
    spacing_nxt = spacing_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_LAYOUT:  layout_nxt  = cfg_data[LAYOUT_W-1:0];
        default:     spacing_nxt = cfg_data[SPACE_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      layout_r  <= LAYOUT_RIGHT;
      spacing_r <= SPACE_W'(100);
    end else begin
      layout_r  <= layout_nxt;
      spacing_r <= spacing_nxt;
    end
  end

  // a transfer lands in the queue as soon as there is room
  assign in_tready = ~q_full;
  assign take      = in_tvalid & ~q_full;

  lsp_front #(.SENSORS_PER_BAR(SENSORS_PER_BAR)) u_front (
    .clk(clk), .rst_n(rst_n), .layout_mode(layout_r), .take(take),
    .front_mask(in_tdata[SENSORS_PER_BAR-1:0]),
    .back_mask(in_tdata[2*SENSORS_PER_BAR-1:SENSORS_PER_BAR]),
    .item(f_item)
  );

  lsp_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .push(take), .push_data(f_item), .full(q_full),
    .pop(q_pop), .empty(q_empty), .pop_data(q_item)
  );

  lsp_div u_div (
    .clk(clk), .rst_n(rst_n), .req(div_req), .done(div_done), .quotient(div_quot)
  );

  lsp_back u_back (
    .clk(clk), .rst_n(rst_n), .bar_spacing(spacing_r), .q_empty(q_empty),
    .q_data(q_item), .q_pop(q_pop), .div_req(div_req), .div_done(div_done),
    .div_quot(div_quot), .out_valid(out_tvalid), .out_ready(out_tready),
    .out_item(o_item), .out_angle(o_angle)
  );

  assign out_tdata = {2'b00, o_item.back_lost, o_item.front_lost, o_angle,
                      o_item.lateral, o_item.back_pos, o_item.front_pos};

endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
// Testbench for the line sensor position estimator: directed and random samples, scoreboard.
module testbench;
  import lsp_pkg::*;

  localparam int unsigned N_RANDOM  = 1350;
  localparam longint      CYCLE_CAP = 80_000_000;

  typedef struct packed {
    logic             back_lost;
    logic             front_lost;
    logic [ANG_W-1:0] heading;
    logic [POS_W-1:0] lateral;
    logic [POS_W-1:0] back_pos;
    logic [POS_W-1:0] front_pos;
  } bar_result_t;

  // Tracks layout, spacing and held positions; predicts one result per sample.
  class position_scoreboard;
    logic [LAYOUT_W-1:0] layout;
    logic [SPACE_W-1:0]  spacing;
    logic [POS_W-1:0]    held_front, held_back;
    bar_result_t         pending[$];
    int                  errors;

    function void reset_state();
      layout     = LAYOUT_RIGHT;
      spacing    = 10'd100;
      held_front = '0;
      held_back  = '0;
      errors     = 0;
    endfunction

    function void write_reg(logic [0:0] idx, logic [9:0] value);
      if (idx == CFG_LAYOUT) layout = value[LAYOUT_W-1:0];
      else spacing = value;
    endfunction

    // Sensor bit and position of each scan slot for the active layout.
    function void slot_info(logic [LAYOUT_W-1:0] md, int slot,
                            output int sbit, output int spos);
      int mid_bit[8] = '{4, 3, 5, 2, 6, 1, 7, 0};
      int mid_pos[8] = '{50, 40, 60, 30, 70, 20, 80, 10};
      if (md == LAYOUT_LEFT) begin
        sbit = slot;
        spos = 10 * (slot + 1);
      end else if (md == LAYOUT_MIDDLE) begin
        sbit = mid_bit[slot];
        spos = mid_pos[slot];
      end else begin
        sbit = 7 - slot;
        spos = 80 - 10 * slot;
      end
    endfunction

    function logic [POS_W-1:0] locate(logic [7:0] mask, logic [POS_W-1:0] held,
                                      output logic lost);
      int sbit, spos, nbit, npos;
      for (int i = 0; i < 8; i++) begin
        slot_info(layout, i, sbit, spos);
        if (mask[sbit]) begin
          if (i < 7) begin
            slot_info(layout, i + 1, nbit, npos);
            if (mask[nbit]) spos = (spos + npos) / 2;
          end
          lost = 1'b0;
          return POS_W'(spos);
        end
      end
      lost = 1'b1;
      return held;
    endfunction

    // Arctangent of p/q (p <= q) as a Q40 power series.
    function longint unsigned arctan_q40(longint unsigned p, longint unsigned q);
      longint unsigned den, term, total;
      den   = p * p + q * q;
      term  = 64'd1 << 40;
      total = 0;
      if (den == 0) return 0;
      for (int n = 1; n <= 48; n++) begin
        total += term;
        term = term * (p * p) / den;
        term = term * (2 * n) / (2 * n + 1);
      end
      return total * (p * q) / den;
    endfunction

    function void note_sample(logic [7:0] fmask, logic [7:0] bmask);
      bar_result_t     r;
      logic            fl, bl;
      int              f, b, d;
      longint unsigned m, v, mag;
      r.front_pos  = locate(fmask, held_front, fl);
      r.back_pos   = locate(bmask, held_back, bl);
      r.front_lost = fl;
      r.back_lost  = bl;
      held_front   = r.front_pos;
      held_back    = r.back_pos;
      f = r.front_pos;
      b = r.back_pos;
      r.lateral = POS_W'((f + b) / 2 - 45);
      d = f - b;
      if (d == 0) begin
        r.heading = '0;
      end else begin
        m = (d < 0) ? -d : d;
        if (m <= spacing) v = arctan_q40(m, spacing);
        else v = 2 * arctan_q40(1, 1) - arctan_q40(spacing, m);
        mag = (v + (64'd1 << 26)) >> 27;
        r.heading = (d < 0) ? ANG_W'(-mag) : ANG_W'(mag);
      end
      pending.push_back(r);
    endfunction

    function void check_result(logic [39:0] data);
      bar_result_t got, want;
      got = data[37:0];
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.front_pos !== want.front_pos)
        $display("%0t: front_position exp %0d got %0d", $time, want.front_pos, got.front_pos);
      if (got.back_pos !== want.back_pos)
        $display("%0t: back_position exp %0d got %0d", $time, want.back_pos, got.back_pos);
      if (got.lateral !== want.lateral)
        $display("%0t: lateral_offset exp %0d got %0d", $time,
                 $signed(want.lateral), $signed(got.lateral));
      if (got.heading !== want.heading)
        $display("%0t: heading_angle exp %0d got %0d", $time,
                 $signed(want.heading), $signed(got.heading));
      if (got.front_lost !== want.front_lost)
        $display("%0t: front_lost exp %0b got %0b", $time, want.front_lost, got.front_lost);
      if (got.back_lost !== want.back_lost)
        $display("%0t: back_lost exp %0b got %0b", $time, want.back_lost, got.back_lost);
      if (data[39:38] !== 2'b00)
        $display("%0t: padding exp 0 got %0b", $time, data[39:38]);
      if (got !== want || data[39:38] !== 2'b00) errors++;
    endfunction
  endclass

  logic        clk, rst_n;
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [9:0]  cfg_data;
  logic        in_tvalid, in_tready;
  logic [15:0] in_tdata;      // front_mask, back_mask (from bit 0 up)
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // front_position, back_position, lateral_offset, heading_angle, front_lost,
  // back_lost (from bit 0 up), zero padded
  logic [39:0] out_tdata;

  position_scoreboard sb;
  longint             cycles = 0;
  int                 stall_left = 0;

  line_sensor_position_estimator u_top (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
    .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Mostly no gap, some short ones, a few long.
  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Random receiver stalls and result checks, with the timeout counter alongside.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("*** FAILED ***");
      $finish;
    end
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else begin
      stall_left <= pick_gap();
      out_tready <= 1'b1;
    end
  end

  // Pulse the write enable for one edge, then idle before returning.
  task automatic write_reg(logic [0:0] idx, logic [9:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.write_reg(idx, value);
    @(posedge clk);
  endtask

  // Hold the sample until the block takes it, then note it.
  task automatic send_sample(logic [7:0] fmask, logic [7:0] bmask);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {bmask, fmask};
    do @(posedge clk); while (!in_tready);
    sb.note_sample(fmask, bmask);
  endtask

  // Drop valid and wait for every pending result, then a short settle.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Random sample: mostly a contiguous line of one or two sensors, some noise, some empty, some full.
  function logic [7:0] random_mask();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return 8'($urandom_range(1, 3) << $urandom_range(0, 7));
    if (r < 8) return 8'($urandom);
    if (r < 9) return 8'h00;
    return 8'hFF;
  endfunction

  task automatic random_phase(int count);
    repeat (count) send_sample(random_mask(), random_mask());
    drain();
  endtask

  initial begin
    sb = new();
    sb.reset_state();
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: lost bars with reset hold, extremes, pairs, last slot alone.
    send_sample(8'h00, 8'h00);
    send_sample(8'h80, 8'h01);
    send_sample(8'h00, 8'h00);
    send_sample(8'hFF, 8'hFF);
    send_sample(8'hC0, 8'h03);
    send_sample(8'h01, 8'h80);
    send_sample(8'hAA, 8'h55);
    send_sample(8'h18, 8'h00);
    drain();
    write_reg(CFG_LAYOUT, 10'(LAYOUT_MIDDLE));
    write_reg(CFG_SPACING, 10'd1023);
    send_sample(8'h10, 8'h01);
    send_sample(8'h18, 8'h81);
    send_sample(8'h01, 8'h00);
    send_sample(8'h00, 8'h80);
    drain();
    // Zero spacing gives half pi for any nonzero difference.
    write_reg(CFG_SPACING, 10'd0);
    write_reg(CFG_LAYOUT, 10'(LAYOUT_LEFT));
    send_sample(8'h01, 8'h80);
    send_sample(8'h80, 8'h01);
    send_sample(8'h10, 8'h10);
    drain();
    // Unused layout code behaves like right.
    write_reg(CFG_LAYOUT, 10'd3);
    write_reg(CFG_SPACING, 10'd1);
    send_sample(8'h01, 8'h80);
    send_sample(8'h06, 8'h30);
    drain();

    // Random phases over several settings, extremes included.
    write_reg(CFG_LAYOUT, 10'(LAYOUT_RIGHT));
    write_reg(CFG_SPACING, 10'd100);
    random_phase(N_RANDOM / 5);
    write_reg(CFG_LAYOUT, 10'(LAYOUT_LEFT));
    write_reg(CFG_SPACING, 10'd1);
    random_phase(N_RANDOM / 5);
    write_reg(CFG_LAYOUT, 10'(LAYOUT_MIDDLE));
    write_reg(CFG_SPACING, 10'd1023);
    random_phase(N_RANDOM / 5);
    write_reg(CFG_LAYOUT, 10'd3);
    write_reg(CFG_SPACING, 10'($urandom_range(1, 1023)));
    random_phase(N_RANDOM / 5);
    write_reg(CFG_LAYOUT, 10'(LAYOUT_MIDDLE));
    write_reg(CFG_SPACING, 10'd40);
    random_phase(N_RANDOM / 5);

    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
